// ===== hw/rtl/u8pt_pkg.sv =====
`default_nettype none

package u8pt_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } text_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic [1:0]  char_class;
    logic        piece_start;
    logic        undecided;
    logic        all_decided;
    logic        text_end;
  } result_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
  } cp_t;

  localparam int MaxCp = 3;

  // Everything one text byte releases: up to three codepoints.
  typedef struct packed {
    logic [1:0]           cp_count;
    cp_t [MaxCp-1:0]      cps;
    logic                 text_last;
  } group_t;

  localparam logic [1:0] CLS_SPACE  = 2'd0;
  localparam logic [1:0] CLS_LETTER = 2'd1;
  localparam logic [1:0] CLS_NUMBER = 2'd2;
  localparam logic [1:0] CLS_OTHER  = 2'd3;
  localparam logic [2:0] RUN_NONE   = 3'd4;

  localparam int MidDepthDefault = 4;
  localparam int OutDepthDefault = 2;

  localparam int NumLetterSpans = 11;
  localparam logic [20:0] LETTER_LO [NumLetterSpans] = '{
    21'h41, 21'h61, 21'hC0, 21'h370, 21'h400, 21'h3040, 21'h30A0, 21'h3400,
    21'h4E00, 21'hF900, 21'h20000};
  localparam logic [20:0] LETTER_HI [NumLetterSpans] = '{
    21'h5A, 21'h7A, 21'h24F, 21'h3FF, 21'h4FF, 21'h309F, 21'h30FF, 21'h4DBF,
    21'h9FFF, 21'hFAFF, 21'h2A6DF};

  localparam int NumOtherSpans = 5;
  localparam logic [20:0] OTHER_LO [NumOtherSpans] = '{
    21'h20, 21'h3A, 21'h5B, 21'h7B, 21'h09};
  localparam logic [20:0] OTHER_HI [NumOtherSpans] = '{
    21'h2F, 21'h40, 21'h60, 21'h7E, 21'h0D};

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (!b[7]) begin
      n = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      n = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = 3'd4;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  function automatic logic [20:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] n);
    logic [20:0] cp;
    case (n)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  function automatic logic is_letter(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumLetterSpans; k++) begin
      hit = hit | ((cp >= LETTER_LO[k]) && (cp <= LETTER_HI[k]));
    end
    return hit;
  endfunction

  function automatic logic is_known_other(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumOtherSpans; k++) begin
      hit = hit | ((cp >= OTHER_LO[k]) && (cp <= OTHER_HI[k]));
    end
    return hit;
  endfunction

  function automatic logic is_number(input logic [20:0] cp);
    return (cp >= 21'h30) && (cp <= 21'h39);
  endfunction

  function automatic logic is_space(input logic [20:0] cp);
    return (cp == 21'h20) || ((cp >= 21'h09) && (cp <= 21'h0D));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8pt_fifo.sv =====
`default_nettype none

module u8pt_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_fire;
  logic             rd_fire;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_fire = wr_en && !full;
  assign rd_fire = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count <= count + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/u8pt_front.sv =====
`default_nettype none

module u8pt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8pt_pkg::text_t   text,
  output logic              full,
  input  logic              mid_full,
  output logic              mid_wr,
  output u8pt_pkg::group_t  mid_data
);

  import u8pt_pkg::*;

  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [2:0]  needed_length;

  logic [7:0]  b;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [2:0]  len;
  logic [2:0]  need;
  logic [20:0] full_cp;
  logic        complete;
  logic        emit;
  logic        accept;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  always_comb begin
    b        = text.text_byte;
    len      = {1'b0, held_count} + 3'd1;
    b0       = (held_count != 2'd0) ? held_bytes[0] : b;
    b1       = (held_count > 2'd1) ? held_bytes[1] : b;
    b2       = (held_count == 2'd3) ? held_bytes[2] : b;
    need     = (held_count != 2'd0) ? needed_length : seq_len(b0);
    full_cp  = decode(b0, b1, b2, b, need);
    complete = (len >= need);

    mid_data.text_last = text.text_last;
    mid_data.cp_count  = 2'd1;
    for (int k = 0; k < MaxCp; k++) begin
      mid_data.cps[k] = '{code_point: full_cp, byte_count: need};
    end
    emit = 1'b1;

    if (complete) begin
      emit = 1'b1;
    end else if (text.text_last) begin
      // A lead cut short by the end of text stands alone; what follows is decoded afresh.
      mid_data.cps[0] = '{code_point: {13'd0, b0}, byte_count: 3'd1};
      if (len == 3'd2) begin
        mid_data.cp_count = 2'd2;
        mid_data.cps[1]   = '{code_point: {13'd0, b1}, byte_count: 3'd1};
      end else if (len == 3'd3) begin
        if (seq_len(b1) == 3'd2) begin
          mid_data.cp_count = 2'd2;
          mid_data.cps[1]   = '{code_point: decode(b1, b2, b2, b2, 3'd2), byte_count: 3'd2};
        end else begin
          mid_data.cp_count = 2'd3;
          mid_data.cps[1]   = '{code_point: {13'd0, b1}, byte_count: 3'd1};
          mid_data.cps[2]   = '{code_point: {13'd0, b2}, byte_count: 3'd1};
        end
      end
    end else begin
      emit = 1'b0;
    end

    mid_wr = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      held_bytes[held_count] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      needed_length <= '0;
    end else if (accept) begin
      if (emit) begin
        held_count    <= '0;
        needed_length <= '0;
      end else begin
        held_count    <= held_count + 2'd1;
        needed_length <= need;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/u8pt_back.sv =====
`default_nettype none

module u8pt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               mid_empty,
  input  u8pt_pkg::group_t   mid_data,
  output logic               mid_rd,
  input  logic               out_full,
  output logic               out_wr,
  output u8pt_pkg::result_t  out_data
);

  import u8pt_pkg::*;

  logic [1:0] idx;
  logic [2:0] run_class;
  logic       space_pending;
  logic       decided_so_far;

  cp_t        cur;
  logic       fire;
  logic       last_cp;
  logic [1:0] cls;
  logic       dec;
  logic       start;
  logic [2:0] run_class_next;
  logic       space_pending_next;
  logic       decided_next;

  always_comb begin
    cur     = mid_data.cps[idx];
    fire    = !mid_empty && !out_full;
    last_cp = (idx == (mid_data.cp_count - 2'd1));
    dec     = is_letter(cur.code_point) || is_number(cur.code_point) ||
              is_known_other(cur.code_point);

    if (is_space(cur.code_point)) begin
      cls = CLS_SPACE;
    end else if (is_letter(cur.code_point)) begin
      cls = CLS_LETTER;
    end else if (is_number(cur.code_point)) begin
      cls = CLS_NUMBER;
    end else begin
      cls = CLS_OTHER;
    end

    run_class_next     = run_class;
    space_pending_next = space_pending;
    if (space_pending) begin
      start              = 1'b0;
      space_pending_next = 1'b0;
      run_class_next     = {1'b0, cls};
    end else if (run_class == {1'b0, cls}) begin
      start = 1'b0;
    end else begin
      start              = 1'b1;
      run_class_next     = {1'b0, cls};
      space_pending_next = (cur.code_point == 21'h20);
    end
    decided_next = decided_so_far && dec;

    out_data.code_point  = cur.code_point;
    out_data.byte_count  = cur.byte_count;
    out_data.char_class  = cls;
    out_data.piece_start = start;
    out_data.undecided   = !dec;
    out_data.all_decided = decided_next;
    out_data.text_end    = mid_data.text_last && last_cp;

    out_wr = fire;
    mid_rd = fire && last_cp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      run_class      <= RUN_NONE;
      space_pending  <= 1'b0;
      decided_so_far <= 1'b1;
    end else if (fire) begin
      idx <= last_cp ? 2'd0 : idx + 2'd1;
      if (out_data.text_end) begin
        run_class      <= RUN_NONE;
        space_pending  <= 1'b0;
        decided_so_far <= 1'b1;
      end else begin
        run_class      <= run_class_next;
        space_pending  <= space_pending_next;
        decided_so_far <= decided_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_pretokenizer_splitter.sv =====
// UTF-8 pretokenizer front end: bytes in, classified codepoints out.
// The text channel is a queue input: a byte beat is taken at a rising edge with push high
// and full low; text_last marks the final byte of a text.
// The result channel is a queue output: while empty is low the oldest codepoint is on
// result, and it is taken at a rising edge with pop high.
// The front decodes one byte per cycle while full is low and writes the codepoints
// it completes into a small queue; the back classifies one codepoint per cycle, when
// one waits and the output queue has room. Throughput is one byte per cycle while full
// is low. A byte that completes a codepoint passes through the middle queue, the
// classifier and the output queue to the ports; a byte that ends a text mid-sequence
// may release up to three codepoints, which the classifier passes on in turn.
// When pop stays low the output queue fills, then the middle queue, and full rises;
// no beat is lost or repeated.
// Reset empties both queues, drops any partly received sequence and starts a new text.
`default_nettype none

module utf8_pretokenizer_splitter #(
  parameter int MID_DEPTH = u8pt_pkg::MidDepthDefault,
  parameter int OUT_DEPTH = u8pt_pkg::OutDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8pt_pkg::text_t    text,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output u8pt_pkg::result_t  result
);

  import u8pt_pkg::*;

  logic    mid_wr;
  logic    mid_rd;
  logic    mid_full;
  logic    mid_empty;
  group_t  mid_in;
  group_t  mid_out;
  logic    out_wr;
  logic    out_full;
  result_t out_in;

  u8pt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .text     (text),
    .full     (full),
    .mid_full (mid_full),
    .mid_wr   (mid_wr),
    .mid_data (mid_in)
  );

  u8pt_fifo #(
    .WIDTH ($bits(group_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_data (mid_in),
    .rd_en   (mid_rd),
    .rd_data (mid_out),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  u8pt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_out),
    .mid_rd    (mid_rd),
    .out_full  (out_full),
    .out_wr    (out_wr),
    .out_data  (out_in)
  );

  u8pt_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_in),
    .rd_en   (pop),
    .rd_data (result),
    .full    (out_full),
    .empty   (empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/u8pt_checker.sv =====
`default_nettype none

module u8pt_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input u8pt_pkg::result_t  result
);

  import u8pt_pkg::*;

  logic text_start;

  // Set while the next result beat is the first of a text.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_start <= 1'b1;
    end else if (pop && !empty) begin
      text_start <= result.text_end;
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) (!rst && $past(rst)) |-> (empty && !full))
    else $error("queues not cleared after reset");

  a_first_starts_piece: assert property (@(posedge clk) disable iff (rst)
    (!empty && text_start) |-> result.piece_start)
    else $error("first codepoint of a text does not open a piece");

  a_classed_is_decided: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.char_class != CLS_OTHER)) |-> !result.undecided)
    else $error("classified codepoint reported as undecided");

  a_sticky_decided: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.undecided) |-> !result.all_decided)
    else $error("undecided codepoint left all_decided set");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result beat changed or vanished");

endmodule

bind utf8_pretokenizer_splitter u8pt_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
